[rtl/rdq_pkg.sv]
// ----------------------------------------------------------------------------
// Ring detect qualifier package
// Shared widths, reset values, operation codes and event codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rdq_pkg;

    localparam int LINES_DEF   = 4;   // default number of line slots
    localparam int RING_W      = 4;   // ring sample bits, one per physical line
    localparam int SEL_W       = 2;   // line select width
    localparam int CNT_W       = 10;  // run counter and threshold width
    localparam int CFG_IDX_W   = 2;   // configuration register index width
    localparam int CFG_DATA_W  = 10;  // configuration write data width
    localparam int IN_DATA_W   = 8;   // ring_bits and line_sel, padded to a byte
    localparam int IN_USER_W   = 2;   // mode
    localparam int OUT_DATA_W  = 8;   // event_line, padded to a byte
    localparam int OUT_USER_W  = 3;   // event_kind and bad_line
    localparam int EVL_W       = 2;   // event_line width
    localparam int KIND_W      = 2;   // event_kind width

    localparam logic [CNT_W-1:0]  RUN_MAX     = 10'd1023;
    localparam logic [CNT_W-1:0]  START_RESET = 10'd10;
    localparam logic [CNT_W-1:0]  END_RESET   = 10'd550;
    localparam logic [RING_W-1:0] VALID_RESET = 4'hF;

    typedef enum logic [IN_USER_W-1:0] {
        MODE_TICK    = 2'd0,
        MODE_POLL    = 2'd1,
        MODE_SEIZE   = 2'd2,
        MODE_RELEASE = 2'd3
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE  = 2'd0,
        KIND_START = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VALID_LINES = 2'd0,
        REG_START_COUNT = 2'd1,
        REG_END_COUNT   = 2'd2
    } t_reg;

    // Saturating increment of a run counter.
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c == RUN_MAX) ? RUN_MAX : c + 1'b1;
    endfunction

endpackage

`default_nettype wire

[rtl/ring_detect_qualifier.sv]
// ----------------------------------------------------------------------------
// Ring detect qualifier
// Per-line ring start and ring end qualification with event polling.
// Each accepted input's result is registered and offered in the next cycle.
// Throughput: one transaction per cycle unless the output stalls; all per-line
// logic works in parallel; the single output register refills as it drains.
// Reset: i_rst_n is synchronous and active low; it restores the register
// defaults, clears all line state and pending events, and enables detection.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_detect_qualifier #(
    parameter int LINES = rdq_pkg::LINES_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Configuration write channel.
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [rdq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [rdq_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input stream.
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    input  wire  [rdq_pkg::IN_DATA_W-1:0]      i_s_tdata,  // ring_bits[3:0], line_sel[5:4]
    input  wire  [rdq_pkg::IN_USER_W-1:0]      i_s_tuser,  // mode[1:0]
    // Output stream.
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    output logic [rdq_pkg::OUT_DATA_W-1:0]     o_m_tdata,  // event_line[1:0]
    output logic [rdq_pkg::OUT_USER_W-1:0]     o_m_tuser   // event_kind[1:0], bad_line[2]
);

    localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int CNT_W = rdq_pkg::CNT_W;

    // Configuration registers.
    logic [rdq_pkg::RING_W-1:0] r_valid_lines;
    logic [CNT_W-1:0]           r_start_count;
    logic [CNT_W-1:0]           r_end_count;

    // Line state.
    logic [LINES-1:0]           r_phase, n_phase;
    logic [CNT_W-1:0]           r_run [LINES];
    logic [CNT_W-1:0]           n_run [LINES];
    logic [LINES-1:0]           r_start_pend, n_start_pend;
    logic [LINES-1:0]           r_end_pend, n_end_pend;
    logic                       r_detect_on, n_detect_on;

    // Output register.
    logic                       r_out_valid;
    logic [rdq_pkg::EVL_W-1:0]  r_ev_line, n_ev_line;
    rdq_pkg::t_kind             r_ev_kind, n_ev_kind;
    logic                       r_bad, n_bad;

    logic                       w_s_acc;
    rdq_pkg::t_mode             w_mode;
    logic [rdq_pkg::RING_W-1:0] w_rings;
    logic [rdq_pkg::SEL_W-1:0]  w_sel;
    logic [LINES-1:0]           w_present;
    logic                       w_sel_ok;
    logic [LINES-1:0]           w_pend;
    logic                       w_any;
    logic [IDX_W-1:0]           w_idx;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign w_s_acc     = i_s_tvalid && o_s_tready;

    assign w_mode  = rdq_pkg::t_mode'(i_s_tuser);
    assign w_rings = i_s_tdata[rdq_pkg::RING_W-1:0];
    assign w_sel   = i_s_tdata[rdq_pkg::RING_W +: rdq_pkg::SEL_W];

    // Only the first four line slots have a ring input and a mask bit.
    for (genvar g = 0; g < LINES; g++) begin : g_present
        if (g < rdq_pkg::RING_W) begin : g_real
            assign w_present[g] = r_valid_lines[g];
        end else begin : g_absent
            assign w_present[g] = 1'b0;
        end
    end

    assign w_sel_ok = (32'(w_sel) < 32'(LINES)) && r_valid_lines[w_sel];

    assign w_pend = r_start_pend | r_end_pend;
    assign w_any  = |w_pend;

    // Lowest line with a pending event.
    always_comb begin
        w_idx = '0;
        for (int i = LINES - 1; i >= 0; i--) begin
            if (w_pend[i]) begin
                w_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        logic [CNT_W-1:0] v_cnt;
        n_phase      = r_phase;
        n_run        = r_run;
        n_start_pend = r_start_pend;
        n_end_pend   = r_end_pend;
        n_detect_on  = r_detect_on;
        n_ev_line    = '0;
        n_ev_kind    = rdq_pkg::KIND_NONE;
        n_bad        = 1'b0;
        v_cnt        = '0;
        unique case (w_mode) inside
            rdq_pkg::MODE_TICK: begin
                if (r_detect_on) begin
                    for (int n = 0; n < LINES; n++) begin
                        if (w_present[n]) begin
                            if (!r_phase[n]) begin
                                v_cnt = w_rings[n % rdq_pkg::RING_W] ?
                                        rdq_pkg::bump(r_run[n]) : '0;
                                if (v_cnt > r_start_count) begin
                                    n_phase[n]      = 1'b1;
                                    n_start_pend[n] = 1'b1;
                                    v_cnt           = '0;
                                end
                            end else begin
                                v_cnt = w_rings[n % rdq_pkg::RING_W] ?
                                        '0 : rdq_pkg::bump(r_run[n]);
                                if (v_cnt > r_end_count) begin
                                    n_phase[n]    = 1'b0;
                                    n_end_pend[n] = 1'b1;
                                    v_cnt         = '0;
                                end
                            end
                            n_run[n] = v_cnt;
                        end
                    end
                end
            end
            rdq_pkg::MODE_POLL: begin
                if (w_any) begin
                    // A start wins when both flags are set; both are cleared.
                    n_ev_kind           = r_start_pend[w_idx] ? rdq_pkg::KIND_START
                                                              : rdq_pkg::KIND_END;
                    n_ev_line           = rdq_pkg::EVL_W'(w_idx);
                    n_start_pend[w_idx] = 1'b0;
                    n_end_pend[w_idx]   = 1'b0;
                end
            end
            rdq_pkg::MODE_SEIZE, rdq_pkg::MODE_RELEASE: begin
                // Seize and release act on line 0's phase only for a valid line.
                if (w_sel_ok) begin
                    n_phase[0]  = 1'b0;
                    n_detect_on = (w_mode == rdq_pkg::MODE_RELEASE);
                end else begin
                    n_bad = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_lines <= rdq_pkg::VALID_RESET;
            r_start_count <= rdq_pkg::START_RESET;
            r_end_count   <= rdq_pkg::END_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rdq_pkg::REG_VALID_LINES: r_valid_lines <= i_cfg_data[rdq_pkg::RING_W-1:0];
                rdq_pkg::REG_START_COUNT: r_start_count <= i_cfg_data[CNT_W-1:0];
                rdq_pkg::REG_END_COUNT:   r_end_count   <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_start_pend <= '0;
            r_end_pend   <= '0;
            r_detect_on  <= 1'b1;
            for (int n = 0; n < LINES; n++) begin
                r_run[n] <= '0;
            end
        end else if (w_s_acc) begin
            r_phase      <= n_phase;
            r_run        <= n_run;
            r_start_pend <= n_start_pend;
            r_end_pend   <= n_end_pend;
            r_detect_on  <= n_detect_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_ev_line <= n_ev_line;
            r_ev_kind <= n_ev_kind;
            r_bad     <= n_bad;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(rdq_pkg::OUT_DATA_W - rdq_pkg::EVL_W){1'b0}}, r_ev_line};
    assign o_m_tuser  = {r_bad, r_ev_kind};

    // Input is held back only while a result waits on a stalled output.
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without output backpressure");

    // A rejected seize or release never comes with an event.
    a_bad_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[2]) |-> (o_m_tuser[1:0] == rdq_pkg::KIND_NONE))
        else $error("bad line flagged together with an event");

    // An accepted valid seize turns detection off.
    a_seize_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && w_mode == rdq_pkg::MODE_SEIZE && w_sel_ok) |=> !r_detect_on)
        else $error("detection still on after seize");

    // A tick with detection off leaves the line phases and pending flags untouched.
    a_tick_off_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && w_mode == rdq_pkg::MODE_TICK && !r_detect_on)
        |=> ($stable(r_phase) && $stable(r_start_pend) && $stable(r_end_pend)))
        else $error("line state changed while detection is off");

endmodule

`default_nettype wire

[verif/ring_detect_qualifier_test.sv]
// ----------------------------------------------------------------------------
// Ring detect qualifier testbench
// Drives tick, poll, seize and release transactions into the qualifier with
// random idle cycles on both streams. A cycle-free model of the per-line ring
// qualification predicts each result, and a checker compares every output
// transaction in order. Directed cases, long runs against lowered thresholds,
// random traffic under several register settings and a long output stall
// are covered.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_detect_qualifier_test;

    localparam int                          LINE_SLOTS  = 4;
    localparam logic [9:0]                  COUNT_CEIL  = 10'd1023;
    // Index with no register behind it.
    localparam logic [rdq_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int unsigned                 IDLE_MAX    = 12;
    localparam int unsigned                 LONG_HOLD   = 200;
    localparam int unsigned                 QUIET_LIMIT = 3000;

    typedef struct packed {
        logic [1:0]     line;
        rdq_pkg::t_kind kind;
        logic           bad_line;
    } t_ring_report;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [rdq_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [rdq_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                           i_s_tvalid  = 1'b0;
    logic                           o_s_tready;
    logic [rdq_pkg::IN_DATA_W-1:0]  i_s_tdata   = '0;   // ring_bits[3:0], line_sel[5:4]
    logic [rdq_pkg::IN_USER_W-1:0]  i_s_tuser   = '0;   // mode[1:0]
    logic                           o_m_tvalid;
    logic                           i_m_tready  = 1'b0;
    logic [rdq_pkg::OUT_DATA_W-1:0] o_m_tdata;          // event_line[1:0]
    logic [rdq_pkg::OUT_USER_W-1:0] o_m_tuser;          // event_kind[1:0], bad_line[2]

    // Predicted line state and register copies.
    logic       ringing    [LINE_SLOTS];
    logic [9:0] run_len    [LINE_SLOTS];
    logic       start_flag [LINE_SLOTS];
    logic       end_flag   [LINE_SLOTS];
    logic       detect_en;
    logic [3:0] line_mask;
    logic [9:0] start_thr;
    logic [9:0] end_thr;

    t_ring_report expected_reports[$];
    t_ring_report want;
    int unsigned  mismatches   = 0;
    int unsigned  quiet_cycles = 0;
    int unsigned  idle_max     = IDLE_MAX;
    bit           hold_request = 1'b0;

    ring_detect_qualifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [9:0] saturating_step(logic [9:0] count);
        return (count == COUNT_CEIL) ? COUNT_CEIL : count + 10'd1;
    endfunction

    // Advances the predicted state by one input transaction and returns
    // the result it should produce.
    function automatic t_ring_report qualify_item(rdq_pkg::t_mode op, logic [3:0] rings,
                                                  logic [1:0] sel);
        t_ring_report rep;
        bit           found;
        int           n;
        rep.line     = 2'd0;
        rep.kind     = rdq_pkg::KIND_NONE;
        rep.bad_line = 1'b0;
        found        = 1'b0;
        case (op)
            rdq_pkg::MODE_TICK: begin
                if (detect_en) begin
                    for (n = 0; n < LINE_SLOTS; n++) begin
                        if (line_mask[n]) begin
                            if (!ringing[n]) begin
                                run_len[n] = rings[n] ? saturating_step(run_len[n]) : 10'd0;
                                if (run_len[n] > start_thr) begin
                                    ringing[n]    = 1'b1;
                                    start_flag[n] = 1'b1;
                                    run_len[n]    = 10'd0;
                                end
                            end else begin
                                run_len[n] = rings[n] ? 10'd0 : saturating_step(run_len[n]);
                                if (run_len[n] > end_thr) begin
                                    ringing[n]  = 1'b0;
                                    end_flag[n] = 1'b1;
                                    run_len[n]  = 10'd0;
                                end
                            end
                        end
                    end
                end
            end
            rdq_pkg::MODE_POLL: begin
                // Every slot is scanned, whether the line is present or not.
                for (n = 0; n < LINE_SLOTS && !found; n++) begin
                    if (start_flag[n] || end_flag[n]) begin
                        rep.kind      = start_flag[n] ? rdq_pkg::KIND_START
                                                      : rdq_pkg::KIND_END;
                        rep.line      = 2'(n);
                        start_flag[n] = 1'b0;
                        end_flag[n]   = 1'b0;
                        found         = 1'b1;
                    end
                end
            end
            default: begin
                // Seize and release act on line 0, whichever valid line is named.
                if (line_mask[sel]) begin
                    ringing[0] = 1'b0;
                    detect_en  = (op == rdq_pkg::MODE_RELEASE);
                end else begin
                    rep.bad_line = 1'b1;
                end
            end
        endcase
        return rep;
    endfunction

    task automatic send_item(rdq_pkg::t_mode op, logic [3:0] rings, logic [1:0] sel);
        int unsigned gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, sel, rings};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        expected_reports.push_back(qualify_item(op, rings, sel));
    endtask

    // Stops offering input and waits until every predicted result is out.
    task automatic drain_stream();
        i_s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [rdq_pkg::CFG_IDX_W-1:0] index,
                             logic [rdq_pkg::CFG_DATA_W-1:0] value);
        drain_stream();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        case (index)
            rdq_pkg::REG_VALID_LINES: line_mask = value[3:0];
            rdq_pkg::REG_START_COUNT: start_thr = value;
            rdq_pkg::REG_END_COUNT:   end_thr   = value;
            default: ;
        endcase
    endtask

    task automatic set_thresholds(logic [rdq_pkg::CFG_DATA_W-1:0] mask,
                                  logic [9:0] start_value, logic [9:0] end_value);
        write_reg(rdq_pkg::REG_VALID_LINES, mask);
        write_reg(rdq_pkg::REG_START_COUNT, start_value);
        write_reg(rdq_pkg::REG_END_COUNT, end_value);
    endtask

    // Ring samples hold for a while per line so that thresholds are crossed.
    task automatic random_items(int unsigned count);
        logic [3:0]  rings;
        int unsigned pick;
        rings = 4'($urandom);
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                rings = 4'($urandom);
            else if ($urandom_range(0, 5) == 0)
                rings[$urandom_range(0, 3)] ^= 1'b1;
            if (pick < 60)
                send_item(rdq_pkg::MODE_TICK, rings, 2'($urandom));
            else if (pick < 85)
                send_item(rdq_pkg::MODE_POLL, 4'($urandom), 2'($urandom));
            else if (pick < 90)
                send_item(rdq_pkg::MODE_SEIZE, 4'($urandom), 2'($urandom));
            else
                send_item(rdq_pkg::MODE_RELEASE, 4'($urandom), 2'($urandom));
        end
    endtask

    task automatic test_directed_operations();
        idle_max = IDLE_MAX;
        set_thresholds(10'h00F, 10'd0, 10'd0);
        send_item(rdq_pkg::MODE_POLL, 4'h0, 2'd0);          // nothing pending yet
        send_item(rdq_pkg::MODE_TICK, 4'hF, 2'd3);          // every line starts ringing
        send_item(rdq_pkg::MODE_POLL, 4'h0, 2'd0);
        send_item(rdq_pkg::MODE_TICK, 4'h0, 2'd0);          // lines 1 to 3 hold both flags
        repeat (4) send_item(rdq_pkg::MODE_POLL, 4'hF, 2'd3);
        send_item(rdq_pkg::MODE_POLL, 4'h0, 2'd0);
        send_item(rdq_pkg::MODE_SEIZE, 4'h0, 2'd3);         // detection off
        send_item(rdq_pkg::MODE_TICK, 4'hF, 2'd0);
        send_item(rdq_pkg::MODE_POLL, 4'h0, 2'd0);
        send_item(rdq_pkg::MODE_RELEASE, 4'h0, 2'd1);
        write_reg(rdq_pkg::REG_VALID_LINES, 10'h3FA);       // lines 1 and 3 present
        write_reg(REG_UNUSED, 10'h3FF);
        send_item(rdq_pkg::MODE_SEIZE, 4'h0, 2'd0);         // absent line, rejected
        send_item(rdq_pkg::MODE_RELEASE, 4'h0, 2'd2);
        send_item(rdq_pkg::MODE_TICK, 4'hF, 2'd0);
        send_item(rdq_pkg::MODE_POLL, 4'h0, 2'd0);
        send_item(rdq_pkg::MODE_POLL, 4'h0, 2'd0);
        write_reg(rdq_pkg::REG_VALID_LINES, 10'h00F);
        send_item(rdq_pkg::MODE_TICK, 4'hF, 2'd0);
        // Line 0 goes back to idle, the other ringing lines do not.
        send_item(rdq_pkg::MODE_SEIZE, 4'h0, 2'd2);
        send_item(rdq_pkg::MODE_RELEASE, 4'h0, 2'd1);
        send_item(rdq_pkg::MODE_TICK, 4'h0, 2'd0);
        repeat (3) send_item(rdq_pkg::MODE_POLL, 4'h0, 2'd0);
    endtask

    task automatic test_long_runs();
        idle_max = 0;
        set_thresholds(10'h00F, 10'd1023, 10'd1023);
        repeat (50) send_item(rdq_pkg::MODE_TICK, 4'hF, 2'($urandom));
        send_item(rdq_pkg::MODE_POLL, 4'h0, 2'd0);
        // A long run still exceeds a threshold lowered below it.
        write_reg(rdq_pkg::REG_START_COUNT, 10'd0);
        send_item(rdq_pkg::MODE_TICK, 4'hF, 2'd0);
        repeat (5) send_item(rdq_pkg::MODE_POLL, 4'h0, 2'd0);
        repeat (60) send_item(rdq_pkg::MODE_TICK, 4'h0, 2'($urandom));
        send_item(rdq_pkg::MODE_POLL, 4'h0, 2'd0);
        write_reg(rdq_pkg::REG_END_COUNT, 10'd40);
        send_item(rdq_pkg::MODE_TICK, 4'h0, 2'd0);
        repeat (5) send_item(rdq_pkg::MODE_POLL, 4'h0, 2'd0);
    endtask

    task automatic test_random_traffic();
        idle_max = IDLE_MAX;
        set_thresholds(10'h00F, rdq_pkg::START_RESET, rdq_pkg::END_RESET);
        random_items(90);
        idle_max = 0;
        set_thresholds(10'($urandom), 10'($urandom_range(0, 3)), 10'($urandom_range(0, 5)));
        random_items(70);
        idle_max = IDLE_MAX;
        set_thresholds(10'h00F, 10'd0, 10'd0);
        random_items(70);
        set_thresholds(10'($urandom), 10'($urandom_range(0, 6)), 10'($urandom_range(0, 20)));
        random_items(90);
        set_thresholds(10'h3F0, 10'd1, 10'd1);     // no line present
        random_items(30);
    endtask

    task automatic test_output_backpressure();
        idle_max = 0;
        set_thresholds(10'h00F, 10'd1, 10'd2);
        hold_request = 1'b1;
        random_items(60);
        drain_stream();
        idle_max = IDLE_MAX;
        random_items(40);
    endtask

    // Result side: random ready gaps, plus one long hold on request.
    initial begin : result_sink
        int unsigned pause;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            pause = $urandom_range(0, idle_max);
            if (pause > 0) begin
                i_m_tready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && o_m_tvalid === 1'b1));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: tdata %h tuser %h",
                             o_m_tdata, o_m_tuser);
            end else begin
                want = expected_reports.pop_front();
                if (o_m_tdata !== {6'b0, want.line} || o_m_tuser !== {want.bad_line, want.kind})
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected line %0d kind %0d bad %0d, ",
                                 want.line, want.kind, want.bad_line,
                                 "got line %0d kind %0d bad %0d (tdata %h)",
                                 o_m_tdata[1:0], o_m_tuser[1:0], o_m_tuser[2], o_m_tdata);
                end
            end
        end
    end

    // Ends a hung run: counts cycles in which no transaction happens anywhere.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready === 1'b1)
                || (o_m_tvalid === 1'b1 && i_m_tready)
                || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        for (int n = 0; n < LINE_SLOTS; n++) begin
            ringing[n]    = 1'b0;
            run_len[n]    = 10'd0;
            start_flag[n] = 1'b0;
            end_flag[n]   = 1'b0;
        end
        detect_en = 1'b1;
        line_mask = rdq_pkg::VALID_RESET;
        start_thr = rdq_pkg::START_RESET;
        end_thr   = rdq_pkg::END_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_operations();
        test_long_runs();
        test_random_traffic();
        test_output_backpressure();
        drain_stream();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
